FILE: design/nlp_pkg.sv
// ============================================================================
// nlp_pkg
// Shared types and constants for the numeric literal parser.
// ============================================================================
package nlp_pkg;

    localparam int CHAR_W  = 8;
    localparam int VALUE_W = 32;
    localparam int SHIFT_W = 6;
    localparam int DIGIT_W = 4;

    // Character codes
    localparam logic [CHAR_W-1:0] CH_NUL   = 8'h00;
    localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
    localparam logic [CHAR_W-1:0] CH_LF    = 8'h0A;
    localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
    localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;
    localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
    localparam logic [CHAR_W-1:0] CH_0     = 8'h30;
    localparam logic [CHAR_W-1:0] CH_7     = 8'h37;
    localparam logic [CHAR_W-1:0] CH_9     = 8'h39;
    localparam logic [CHAR_W-1:0] CH_A_UP  = 8'h41;
    localparam logic [CHAR_W-1:0] CH_F_UP  = 8'h46;
    localparam logic [CHAR_W-1:0] CH_K_UP  = 8'h4B;
    localparam logic [CHAR_W-1:0] CH_M_UP  = 8'h4D;
    localparam logic [CHAR_W-1:0] CH_X_UP  = 8'h58;
    localparam logic [CHAR_W-1:0] CH_A_LO  = 8'h61;
    localparam logic [CHAR_W-1:0] CH_F_LO  = 8'h66;
    localparam logic [CHAR_W-1:0] CH_K_LO  = 8'h6B;
    localparam logic [CHAR_W-1:0] CH_M_LO  = 8'h6D;
    localparam logic [CHAR_W-1:0] CH_X_LO  = 8'h78;

    localparam logic [SHIFT_W-1:0] K_SHIFT   = 6'd10;
    localparam logic [SHIFT_W-1:0] M_SHIFT   = 6'd20;
    localparam logic [SHIFT_W-1:0] SHIFT_MAX = 6'd63;

    typedef enum logic [2:0] {
        PH_PREFIX  = 3'd0,
        PH_ZERO    = 3'd1,
        PH_HEX     = 3'd2,
        PH_OCT     = 3'd3,
        PH_DEC     = 3'd4,
        PH_DONE    = 3'd5,
        PH_FORCED0 = 3'd6
    } phase_t;

    typedef enum logic [1:0] {
        SIGN_NONE  = 2'd0,
        SIGN_PLUS  = 2'd1,
        SIGN_MINUS = 2'd2
    } sign_t;

    // Decoded view of one character
    typedef struct packed {
        logic               is_nul;
        logic               is_blank;
        logic               is_sign;
        logic               is_minus;
        logic               is_k;
        logic               is_m;
        logic               is_zero;
        logic               is_x;
        logic               dec_ok;
        logic               oct_ok;
        logic               hex_ok;
        logic [DIGIT_W-1:0] digit;
    } char_class_t;

endpackage

FILE: design/nlp_char_if.sv
// ============================================================================
// nlp_char_if
// Valid/ready channel carrying one character code per transfer.
// ============================================================================
interface nlp_char_if;
    logic                         valid;
    logic                         ready;
    logic [nlp_pkg::CHAR_W-1:0]   char_code;

    modport source (output valid, output char_code, input ready);
    modport sink   (input valid, input char_code, output ready);
endinterface

FILE: design/nlp_value_if.sv
// ============================================================================
// nlp_value_if
// Valid/ready channel carrying one parsed value per transfer.
// ============================================================================
interface nlp_value_if;
    logic                                valid;
    logic                                ready;
    logic signed [nlp_pkg::VALUE_W-1:0]  value;

    modport source (output valid, output value, input ready);
    modport sink   (input valid, input value, output ready);
endinterface

FILE: design/nlp_char_decode.sv
// ============================================================================
// nlp_char_decode
// Classifies one character: blanks, signs, scale letters, digit values.
// ============================================================================
module nlp_char_decode (
    input  logic [nlp_pkg::CHAR_W-1:0] char_code,
    output nlp_pkg::char_class_t       cls
);
    import nlp_pkg::*;

    always_comb
    begin
        cls          = '0;
        cls.is_nul   = (char_code == CH_NUL);
        cls.is_blank = (char_code == CH_SPACE) || (char_code == CH_TAB) ||
                       (char_code == CH_LF);
        cls.is_sign  = (char_code == CH_PLUS) || (char_code == CH_MINUS);
        cls.is_minus = (char_code == CH_MINUS);
        cls.is_k     = (char_code == CH_K_LO) || (char_code == CH_K_UP);
        cls.is_m     = (char_code == CH_M_LO) || (char_code == CH_M_UP);
        cls.is_zero  = (char_code == CH_0);
        cls.is_x     = (char_code == CH_X_LO) || (char_code == CH_X_UP);
        if (char_code inside {[CH_0:CH_9]})
        begin
            cls.dec_ok = 1'b1;
            cls.hex_ok = 1'b1;
            cls.oct_ok = (char_code <= CH_7);
            cls.digit  = DIGIT_W'(char_code - CH_0);
        end
        else if (char_code inside {[CH_A_LO:CH_F_LO]})
        begin
            cls.hex_ok = 1'b1;
            cls.digit  = DIGIT_W'(char_code - CH_A_LO + 8'd10);
        end
        else if (char_code inside {[CH_A_UP:CH_F_UP]})
        begin
            cls.hex_ok = 1'b1;
            cls.digit  = DIGIT_W'(char_code - CH_A_UP + 8'd10);
        end
    end

endmodule

FILE: design/nlp_parse_core.sv
// ============================================================================
// nlp_parse_core
// Parser state, digit accumulation and the registered result stage.
// ============================================================================
module nlp_parse_core (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 item_valid,
    input  nlp_pkg::char_class_t cls,
    output logic                 item_ready,
    nlp_value_if.source          results
);
    import nlp_pkg::*;

    phase_t               phase_reg, phase_next;
    sign_t                sign_reg, sign_next;
    logic [VALUE_W-1:0]   acc_reg, acc_next;
    logic [SHIFT_W-1:0]   shift_reg, shift_next;
    logic                 out_valid_reg, out_valid_next;
    logic [VALUE_W-1:0]   value_reg, value_next;

    logic                 take;
    logic [SHIFT_W:0]     shift_sum;
    logic [SHIFT_W-1:0]   shift_add;
    logic [SHIFT_W-1:0]   shift_sat;
    logic [VALUE_W-1:0]   dec_acc, oct_acc, hex_acc;
    logic [VALUE_W-1:0]   shifted, final_value;

    // A terminator waits only while the result register is full and stalled
    assign item_ready = !cls.is_nul || !out_valid_reg || results.ready;
    assign take       = item_valid && item_ready;

    assign shift_add = cls.is_m ? M_SHIFT : K_SHIFT;
    assign shift_sum = {1'b0, shift_reg} + {1'b0, shift_add};
    assign shift_sat = shift_sum[SHIFT_W] ? SHIFT_MAX : shift_sum[SHIFT_W-1:0];

    assign dec_acc = (acc_reg << 3) + (acc_reg << 1) + VALUE_W'(cls.digit);
    assign oct_acc = (acc_reg << 3) + VALUE_W'(cls.digit);
    assign hex_acc = (acc_reg << 4) + VALUE_W'(cls.digit);

    // Shift of 32 or more flushes everything out
    assign shifted     = shift_reg[SHIFT_W-1] ? '0 : (acc_reg << shift_reg[SHIFT_W-2:0]);
    assign final_value = (phase_reg == PH_FORCED0) ? '0 :
                         (sign_reg == SIGN_MINUS) ? (VALUE_W'(0) - shifted) : shifted;

    always_comb
    begin
        phase_next     = phase_reg;
        sign_next      = sign_reg;
        acc_next       = acc_reg;
        shift_next     = shift_reg;
        value_next     = value_reg;
        out_valid_next = out_valid_reg && !results.ready;
        if (take)
        begin
            if (cls.is_nul)
            begin
                out_valid_next = 1'b1;
                value_next     = final_value;
                phase_next     = PH_PREFIX;
                sign_next      = SIGN_NONE;
                acc_next       = '0;
                shift_next     = '0;
            end
            else
            begin
                case (phase_reg)
                    PH_PREFIX:
                    begin
                        if (cls.is_blank)
                        begin
                            phase_next = PH_PREFIX;
                        end
                        else if (cls.is_sign)
                        begin
                            if (sign_reg != SIGN_NONE)
                                phase_next = PH_FORCED0;
                            else
                                sign_next = cls.is_minus ? SIGN_MINUS : SIGN_PLUS;
                        end
                        else if (cls.is_k || cls.is_m)
                        begin
                            shift_next = shift_sat;
                        end
                        else if (cls.is_zero)
                        begin
                            phase_next = PH_ZERO;
                        end
                        else if (cls.dec_ok)
                        begin
                            acc_next   = dec_acc;
                            phase_next = PH_DEC;
                        end
                        else
                        begin
                            phase_next = PH_DONE;
                        end
                    end
                    PH_ZERO:
                    begin
                        if (cls.is_x)
                            phase_next = PH_HEX;
                        else if (cls.oct_ok)
                        begin
                            acc_next   = oct_acc;
                            phase_next = PH_OCT;
                        end
                        else
                            phase_next = PH_DONE;
                    end
                    PH_HEX:
                    begin
                        if (cls.hex_ok)
                            acc_next = hex_acc;
                        else
                            phase_next = PH_DONE;
                    end
                    PH_OCT:
                    begin
                        if (cls.oct_ok)
                            acc_next = oct_acc;
                        else
                            phase_next = PH_DONE;
                    end
                    PH_DEC:
                    begin
                        if (cls.dec_ok)
                            acc_next = dec_acc;
                        else
                            phase_next = PH_DONE;
                    end
                    default:
                    begin
                        phase_next = phase_reg;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_PREFIX;
            sign_reg      <= SIGN_NONE;
            acc_reg       <= '0;
            shift_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg     <= phase_next;
            sign_reg      <= sign_next;
            acc_reg       <= acc_next;
            shift_reg     <= shift_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

    assign results.valid = out_valid_reg;
    assign results.value = value_reg;

    // Assertions
    a_clear_after_nul: assert property (@(posedge clk) disable iff (!rst_n)
        (take && cls.is_nul) |=> (phase_reg == PH_PREFIX && acc_reg == '0 &&
                                  shift_reg == '0 && sign_reg == SIGN_NONE && out_valid_reg))
        else $error("parser state not cleared after terminator");

    a_no_stall_on_char: assert property (@(posedge clk) disable iff (!rst_n)
        (item_valid && !cls.is_nul) |-> item_ready)
        else $error("non-terminator character stalled");

    a_shift_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
        (take && !cls.is_nul) |=> (shift_reg >= $past(shift_reg)))
        else $error("shift count decreased inside a string");

    a_forced_needs_sign: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_FORCED0) |-> (sign_reg != SIGN_NONE))
        else $error("forced zero without a prior sign");

endmodule

FILE: design/numeric_literal_parser_unit.sv
// ============================================================================
// numeric_literal_parser_unit
// Streaming integer literal parser with automatic radix selection.
// ============================================================================
// Takes one character per transfer on chars and, for each NUL terminator,
// delivers one 32-bit two's complement value on results. A new character is
// accepted every cycle while no terminator waits: each one is registered,
// decoded and then folded into the parser state by a single shift-and-add
// step. The result of a terminator is held in an output register; a further
// terminator waits in the input register only while that register is full
// and stalled, and holds back the characters behind it.
module numeric_literal_parser_unit (
    input  logic        clk,
    input  logic        rst_n,
    nlp_char_if.sink    chars,
    nlp_value_if.source results
);
    import nlp_pkg::*;

    logic               in_valid_reg;
    logic [CHAR_W-1:0]  char_reg;
    logic               core_ready;
    char_class_t        cls;

    assign chars.ready = !in_valid_reg || core_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (chars.ready)
            in_valid_reg <= chars.valid;
    end

    always_ff @(posedge clk)
    begin
        if (chars.ready && chars.valid)
            char_reg <= chars.char_code;
    end

    nlp_char_decode u_decode (
        .char_code (char_reg),
        .cls       (cls)
    );

    nlp_parse_core u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (in_valid_reg),
        .cls        (cls),
        .item_ready (core_ready),
        .results    (results)
    );

endmodule
